// File: rtl/lzsd_pkg.sv
// ----------------------------------------------------------------------------
// lzsd_pkg
// Shared types and constants for the LZSS stream decompressor: parse phases,
// status codes, and the command/status bundles between control and datapath.
// ----------------------------------------------------------------------------
package lzsd_pkg;

    localparam int WINDOW = 4096;
    localparam int HADDR_W = $clog2(WINDOW);
    localparam int COUNT_W = 24;

    typedef enum logic [1:0] {
        PH_FLAG = 2'd0,
        PH_ITEM = 2'd1,
        PH_PAIR = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_RUN      = 3'd0,
        ST_OK       = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_BADDIST  = 3'd4
    } status_t;

    typedef struct packed {
        logic accept;
        logic load_flags;
        logic store_low;
        logic use_flag;
        logic fail_ovf;
        logic fail_bad;
        logic start_copy;
        logic mem_rd;
        logic emit_lit;
        logic emit_copy;
        logic emit_status;
        logic emit_fill;
        logic run_last;
        logic clear_block;
    } cmd_t;

    typedef struct packed {
        logic failed;
        logic phase_pair;
        logic item_ok;
        logic flag_bit;
        logic ovf;
        logic bad_dist;
        logic item_last;
        logic copy_done;
        logic copy_end;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/lzsd_ctrl.sv
// ----------------------------------------------------------------------------
// lzsd_ctrl
// Parser/sequencer state machine. Decodes one compressed byte per item and
// steps copy runs one byte at a time through the history read port.
// ----------------------------------------------------------------------------
module lzsd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  lzsd_pkg::sts_t  sts,
    output lzsd_pkg::cmd_t  cmd
);
    import lzsd_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_DECODE  = 6'b000010,
        S_COPY_RD = 6'b000100,
        S_COPY_WR = 6'b001000,
        S_FINAL   = 6'b010000,
        S_FILL    = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t no_emit_state;
    state_t done_state;

    assign in_stall      = (state_reg != S_IDLE);
    assign no_emit_state = sts.item_last ? S_FINAL : S_FILL;
    assign done_state    = sts.item_last ? S_FINAL : S_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.out_free)
                begin
                    if (sts.failed)
                    begin
                        state_next = no_emit_state;
                    end
                    else if (sts.phase_pair)
                    begin
                        cmd.use_flag = 1'b1;
                        if (sts.ovf)
                        begin
                            cmd.fail_ovf = 1'b1;
                            state_next   = no_emit_state;
                        end
                        else if (sts.bad_dist)
                        begin
                            cmd.fail_bad = 1'b1;
                            state_next   = no_emit_state;
                        end
                        else
                        begin
                            cmd.start_copy = 1'b1;
                            state_next     = S_COPY_RD;
                        end
                    end
                    else if (sts.item_ok)
                    begin
                        if (sts.flag_bit)
                        begin
                            cmd.use_flag = 1'b1;
                            if (sts.ovf)
                            begin
                                cmd.fail_ovf = 1'b1;
                                state_next   = no_emit_state;
                            end
                            else
                            begin
                                cmd.emit_lit = 1'b1;
                                cmd.run_last = ~sts.item_last;
                                state_next   = done_state;
                            end
                        end
                        else
                        begin
                            cmd.store_low = 1'b1;
                            state_next    = no_emit_state;
                        end
                    end
                    else
                    begin
                        cmd.load_flags = 1'b1;
                        state_next     = no_emit_state;
                    end
                end
            end
            S_COPY_RD:
            begin
                if (sts.copy_done)
                begin
                    state_next = done_state;
                end
                else if (sts.ovf)
                begin
                    cmd.fail_ovf = 1'b1;
                    state_next   = done_state;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_COPY_WR;
                end
            end
            S_COPY_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_copy = 1'b1;
                    cmd.run_last  = ~sts.item_last & sts.copy_end;
                    state_next    = S_COPY_RD;
                end
            end
            S_FINAL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_status = 1'b1;
                    cmd.run_last    = 1'b1;
                    cmd.clear_block = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_FILL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_fill = 1'b1;
                    cmd.run_last  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/lzsd_dp.sv
// ----------------------------------------------------------------------------
// lzsd_dp
// Datapath: item capture, flag and pair registers, output count, history
// window memory, copy counters and the output register.
// ----------------------------------------------------------------------------
module lzsd_dp #(
    parameter int MIN_MATCH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [7:0]                   in_byte,
    input  logic                         in_last,
    input  logic                         cfg_we,
    input  logic [lzsd_pkg::COUNT_W-1:0] cfg_data,
    input  lzsd_pkg::cmd_t               cmd,
    output lzsd_pkg::sts_t               sts,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [7:0]                   out_byte,
    output logic                         byte_valid,
    output logic                         run_last,
    output logic [2:0]                   status
);
    import lzsd_pkg::*;

    localparam int LEN_W = $clog2(16 + MIN_MATCH + 1);
    localparam logic [LEN_W-1:0] LEN_ADD = LEN_W'(MIN_MATCH + 1);

    logic [7:0]         history [WINDOW];

    logic [7:0]         item_byte_reg;
    logic               item_last_reg;
    logic [COUNT_W-1:0] expected_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [7:0]         flag_shift_reg;
    logic [3:0]         flag_count_reg;
    phase_t             phase_reg;
    logic [7:0]         pair_low_reg;
    logic               failed_reg;
    status_t            fail_code_reg;
    logic [HADDR_W-1:0] copy_dist_reg;
    logic [LEN_W-1:0]   copy_left_reg;
    logic [7:0]         rd_data_reg;

    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               byte_valid_reg;
    logic               run_last_reg;
    status_t            status_reg;

    logic [HADDR_W-1:0] pair_dist;
    logic [LEN_W-1:0]   len;
    logic [COUNT_W-1:0] count_inc;
    logic [3:0]         flag_count_dec;
    logic               emit_byte;
    logic               emit_any;
    logic               out_free;
    status_t            final_code;

    assign pair_dist      = {item_byte_reg[7:4], pair_low_reg};
    assign len            = LEN_W'(item_byte_reg[3:0]) + LEN_ADD;
    assign count_inc      = out_count_reg + COUNT_W'(1);
    assign flag_count_dec = (flag_count_reg != 4'd0) ? flag_count_reg - 4'd1 : 4'd0;
    assign emit_byte      = cmd.emit_lit | cmd.emit_copy;
    assign emit_any       = emit_byte | cmd.emit_status | cmd.emit_fill;
    assign out_free       = ~out_valid_reg | ~out_stall;

    always_comb
    begin
        if (failed_reg)
        begin
            final_code = fail_code_reg;
        end
        else if (out_count_reg == expected_reg)
        begin
            final_code = ST_OK;
        end
        else
        begin
            final_code = ST_MISMATCH;
        end
    end

    always_comb
    begin
        sts.failed     = failed_reg;
        sts.phase_pair = (phase_reg == PH_PAIR);
        sts.item_ok    = (phase_reg == PH_ITEM) && (flag_count_reg != 4'd0);
        sts.flag_bit   = flag_shift_reg[0];
        sts.ovf        = (out_count_reg >= expected_reg);
        sts.bad_dist   = (pair_dist == '0) || (COUNT_W'(pair_dist) > out_count_reg);
        sts.item_last  = item_last_reg;
        sts.copy_done  = (copy_left_reg == '0);
        sts.copy_end   = (copy_left_reg == LEN_W'(1)) || (count_inc == expected_reg);
        sts.out_free   = out_free;
    end

    // history window
    always_ff @(posedge clk)
    begin
        if (emit_byte)
        begin
            history[out_count_reg[HADDR_W-1:0]] <= cmd.emit_lit ? item_byte_reg : rd_data_reg;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= history[out_count_reg[HADDR_W-1:0] - copy_dist_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_byte_reg <= in_byte;
        end
        if (cmd.start_copy)
        begin
            copy_dist_reg <= pair_dist;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_last_reg  <= 1'b0;
            expected_reg   <= '0;
            out_count_reg  <= '0;
            flag_shift_reg <= '0;
            flag_count_reg <= '0;
            phase_reg      <= PH_FLAG;
            pair_low_reg   <= '0;
            failed_reg     <= 1'b0;
            fail_code_reg  <= ST_RUN;
            copy_left_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                expected_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                item_last_reg <= in_last;
            end
            if (cmd.load_flags)
            begin
                flag_shift_reg <= item_byte_reg;
                flag_count_reg <= 4'd8;
                phase_reg      <= PH_ITEM;
            end
            if (cmd.store_low)
            begin
                pair_low_reg <= item_byte_reg;
                phase_reg    <= PH_PAIR;
            end
            if (cmd.use_flag)
            begin
                flag_shift_reg <= {1'b0, flag_shift_reg[7:1]};
                flag_count_reg <= flag_count_dec;
                phase_reg      <= (flag_count_dec == 4'd0) ? PH_FLAG : PH_ITEM;
            end
            if (cmd.fail_ovf)
            begin
                failed_reg    <= 1'b1;
                fail_code_reg <= ST_OVERFLOW;
            end
            if (cmd.fail_bad)
            begin
                failed_reg    <= 1'b1;
                fail_code_reg <= ST_BADDIST;
            end
            if (cmd.start_copy)
            begin
                copy_left_reg <= len;
            end
            if (cmd.emit_copy)
            begin
                copy_left_reg <= copy_left_reg - LEN_W'(1);
            end
            if (emit_byte)
            begin
                out_count_reg <= count_inc;
            end
            if (cmd.clear_block)
            begin
                out_count_reg  <= '0;
                flag_shift_reg <= '0;
                flag_count_reg <= '0;
                phase_reg      <= PH_FLAG;
                pair_low_reg   <= '0;
                failed_reg     <= 1'b0;
                fail_code_reg  <= ST_RUN;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_any)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_any)
        begin
            out_byte_reg   <= cmd.emit_lit ? item_byte_reg :
                              (cmd.emit_copy ? rd_data_reg : 8'd0);
            byte_valid_reg <= emit_byte;
            run_last_reg   <= cmd.run_last;
            status_reg     <= cmd.emit_status ? final_code : ST_RUN;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign run_last   = run_last_reg;
    assign status     = status_reg;

endmodule

// File: rtl/lzss_stream_decompressor_core.sv
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_core
// LZSS decompressor, 12-bit distance and 4-bit length, over a 4096-byte
// history window, with a final status item per compressed block.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------
//   in      | input     | in_valid / in_stall | in_byte, in_last
//   out     | output    | out_valid/out_stall | out_byte, byte_valid, run_last,
//           |           |                     | status
//   cfg     | input     | cfg_we              | cfg_data (expected_length)
//
// One input item at a time: an accept state, then a decode state. A literal
// is emitted from decode; an item with no byte out (flag byte, pair low byte,
// failed or ignored item) goes on to a fill state that emits the filler item.
// A copy steps a read state and a write state per byte, then an end check.
// With in_last the status item takes the filler's place or follows the last
// byte. Out stalls hold every output state; reset leaves history and data regs.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor_core #(
    parameter int MIN_MATCH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   in_byte,
    input  logic                         in_last,
    input  logic                         cfg_we,
    input  logic [lzsd_pkg::COUNT_W-1:0] cfg_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [7:0]                   out_byte,
    output logic                         byte_valid,
    output logic                         run_last,
    output logic [2:0]                   status
);
    import lzsd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    lzsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    lzsd_dp #(
        .MIN_MATCH (MIN_MATCH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_last   (run_last),
        .status     (status)
    );

endmodule

// File: dv/lzss_stream_decompressor_core_tb.sv
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_core_tb
// Self-checking bench for the LZSS stream decompressor. A directed table covers
// the end-of-block status codes, copy lengths and truncated units, then random
// compressed blocks run under four idle/stall mixes. Each output item is compared
// to a typed table row or a behavioral decoder kept in step with accepted input.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lzsd_pkg::*;

    localparam int MIN_MATCH = 2;
    localparam int LONG_HOLD = 300;
    localparam int SETTLE_CYCLES = 8;

    typedef enum int {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SINK,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        status_t    status;
    } out_item_t;

    typedef struct {
        bit          is_cfg;
        logic [23:0] cfg_val;
        logic [7:0]  in_byte;
        bit          in_last;
        bit          typed;
        logic [7:0]  t_byte;
        bit          t_valid;
        status_t     t_status;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        in_last = 1'b0;
    logic        cfg_we = 1'b0;
    logic [23:0] cfg_data = 24'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_last;
    logic [2:0]  status;

    // decoder state
    logic [7:0]  hist [WINDOW];
    logic [23:0] n_out;
    logic [23:0] want_len;
    logic [7:0]  flag_bits;
    int          flags_left;
    phase_t      dec_phase;
    logic [7:0]  pair_low;
    bit          dec_failed;
    status_t     fail_code;

    out_item_t   decoded_q[$];
    out_item_t   head;
    logic [7:0]  stream_q[$];
    int          stream_out;

    idle_mode_t  idle_mode = IDLE_NONE;
    int          hold_reqs = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          mismatches = 0;

    // flag bytes, literals, pairs and config writes; expected items typed in where obvious
    dir_row_t dir_rows [31] = '{
        '{1'b0, 24'd0, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0, ST_OK},
        '{1'b1, 24'd5, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, ST_RUN},
        '{1'b0, 24'd0, 8'hFD, 1'b0, 1'b1, 8'h00, 1'b0, ST_RUN},
        '{1'b0, 24'd0, 8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1, ST_RUN},
        '{1'b0, 24'd0, 8'h01, 1'b0, 1'b1, 8'h00, 1'b0, ST_RUN},
        '{1'b0, 24'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, ST_RUN},
        '{1'b0, 24'd0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1, ST_RUN},
        '{1'b0, 24'd0, 8'h12, 1'b1, 1'b1, 8'h00, 1'b0, ST_OVERFLOW},
        '{1'b1, 24'hFFFFFF, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, ST_RUN},
        '{1'b0, 24'd0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, ST_RUN},
        '{1'b0, 24'd0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, ST_RUN},
        '{1'b0, 24'd0, 8'h0F, 1'b0, 1'b1, 8'h00, 1'b0, ST_RUN},
        '{1'b0, 24'd0, 8'hAB, 1'b1, 1'b1, 8'h00, 1'b0, ST_BADDIST},
        '{1'b0, 24'd0, 8'h01, 1'b0, 1'b1, 8'h00, 1'b0, ST_RUN},
        '{1'b0, 24'd0, 8'h5A, 1'b0, 1'b1, 8'h5A, 1'b1, ST_RUN},
        '{1'b0, 24'd0, 8'h01, 1'b0, 1'b1, 8'h00, 1'b0, ST_RUN},
        '{1'b0, 24'd0, 8'h0F, 1'b0, 1'b0, 8'h00, 1'b0, ST_RUN},
        '{1'b0, 24'd0, 8'hFF, 1'b0, 1'b1, 8'h00, 1'b0, ST_RUN},
        '{1'b0, 24'd0, 8'hF0, 1'b1, 1'b1, 8'h00, 1'b0, ST_BADDIST},
        '{1'b1, 24'd3, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, ST_RUN},
        '{1'b0, 24'd0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, ST_RUN},
        '{1'b0, 24'd0, 8'h01, 1'b1, 1'b1, 8'h00, 1'b0, ST_MISMATCH},
        '{1'b1, 24'd4, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, ST_RUN},
        '{1'b0, 24'd0, 8'h01, 1'b0, 1'b1, 8'h00, 1'b0, ST_RUN},
        '{1'b0, 24'd0, 8'h33, 1'b0, 1'b1, 8'h33, 1'b1, ST_RUN},
        '{1'b0, 24'd0, 8'h01, 1'b0, 1'b1, 8'h00, 1'b0, ST_RUN},
        '{1'b0, 24'd0, 8'h0F, 1'b1, 1'b0, 8'h00, 1'b0, ST_RUN},
        '{1'b1, 24'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, ST_RUN},
        '{1'b0, 24'd0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, ST_RUN},
        '{1'b0, 24'd0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, ST_RUN},
        '{1'b0, 24'd0, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0, ST_OVERFLOW}
    };

    lzss_stream_decompressor_core #(
        .MIN_MATCH (MIN_MATCH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_last   (run_last),
        .status     (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("lzss_stream_decompressor_core_tb failed");
        $finish;
    end

    function automatic int idle_pct(bit sink_side);
        case (idle_mode)
            IDLE_SRC:  return sink_side ? 0 : 88;
            IDLE_SINK: return sink_side ? 88 : 0;
            IDLE_BOTH: return 34;
            default:   return 0;
        endcase
    endfunction

    task automatic report_miss(string what, logic [7:0] got, logic [7:0] exp_val);
        $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, exp_val);
        mismatches++;
    endtask

    task automatic fail_with(status_t code);
        if (!dec_failed)
        begin
            dec_failed = 1'b1;
            fail_code = code;
        end
    endtask

    task automatic emit_byte(logic [7:0] v, ref out_item_t res[$]);
        hist[n_out[11:0]] = v;
        n_out = n_out + 24'd1;
        res.push_back('{v, 1'b1, 1'b0, ST_RUN});
    endtask

    task automatic take_flag();
        flag_bits = flag_bits >> 1;
        if (flags_left > 0)
            flags_left--;
        dec_phase = (flags_left == 0) ? PH_FLAG : PH_ITEM;
    endtask

    // items produced by one compressed byte
    task automatic lzss_decode_step(logic [7:0] b, bit last, ref out_item_t res[$]);
        logic [11:0] pair_dist;
        logic [23:0] src;
        int          len;
        status_t     fin;
        res.delete();
        if (!dec_failed)
        begin
            if (dec_phase == PH_PAIR)
            begin
                pair_dist = {b[7:4], pair_low};
                len = b[3:0] + MIN_MATCH + 1;
                if (n_out >= want_len)
                    fail_with(ST_OVERFLOW);
                else if (pair_dist == 12'd0 || pair_dist > n_out)
                    fail_with(ST_BADDIST);
                else
                begin
                    for (int n = 0; n < len; n++)
                    begin
                        if (n_out >= want_len)
                        begin
                            fail_with(ST_OVERFLOW);
                            break;
                        end
                        src = n_out - pair_dist;
                        emit_byte(hist[src[11:0]], res);
                    end
                end
                take_flag();
            end
            else if (dec_phase == PH_ITEM)
            begin
                if (flag_bits[0])
                begin
                    if (n_out >= want_len)
                        fail_with(ST_OVERFLOW);
                    else
                        emit_byte(b, res);
                    take_flag();
                end
                else
                begin
                    pair_low = b;
                    dec_phase = PH_PAIR;
                end
            end
            else
            begin
                flag_bits = b;
                flags_left = 8;
                dec_phase = PH_ITEM;
            end
        end
        if (last)
        begin
            fin = dec_failed ? fail_code : ((n_out == want_len) ? ST_OK : ST_MISMATCH);
            res.push_back('{8'h00, 1'b0, 1'b0, fin});
            n_out = 24'd0;
            flag_bits = 8'h00;
            flags_left = 0;
            dec_phase = PH_FLAG;
            pair_low = 8'h00;
            dec_failed = 1'b0;
            fail_code = ST_RUN;
        end
        if (res.size() == 0)
            res.push_back('{8'h00, 1'b0, 1'b0, ST_RUN});
        res[res.size() - 1].run_last = 1'b1;
    endtask

    task automatic send_item(logic [7:0] b, bit last);
        while ($urandom_range(0, 99) < idle_pct(1'b0))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        in_last <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(logic [23:0] v);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        want_len = v;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (decoded_q.size() == 0)
                    report_miss("item with none pending", out_byte, 8'h00);
                else
                begin
                    head = decoded_q.pop_front();
                    if (out_byte !== head.out_byte)
                        report_miss("out_byte", out_byte, head.out_byte);
                    if (byte_valid !== head.byte_valid)
                        report_miss("byte_valid", byte_valid, head.byte_valid);
                    if (run_last !== head.run_last)
                        report_miss("run_last", run_last, head.run_last);
                    if (status !== head.status)
                        report_miss("status", status, head.status);
                end
            end
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < idle_pct(1'b1));
        end
    end

    initial
    begin
        out_item_t   step_q[$];
        logic [7:0]  unit_q[$];
        logic [7:0]  flags;
        logic [23:0] len_val;
        int          target;
        int          lenf;
        int          back_dist;
        int          room;
        int          phase_items;
        bit          allow_bad;
        bit          first_block;

        n_out = 24'd0;
        want_len = 24'd0;
        flag_bits = 8'h00;
        flags_left = 0;
        dec_phase = PH_FLAG;
        pair_low = 8'h00;
        dec_failed = 1'b0;
        fail_code = ST_RUN;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                settle();
                write_cfg(dir_rows[i].cfg_val);
            end
            else
            begin
                send_item(dir_rows[i].in_byte, dir_rows[i].in_last);
                lzss_decode_step(dir_rows[i].in_byte, dir_rows[i].in_last, step_q);
                if (dir_rows[i].typed)
                    decoded_q.push_back('{dir_rows[i].t_byte, dir_rows[i].t_valid, 1'b1,
                                          dir_rows[i].t_status});
                else
                    foreach (step_q[j])
                        decoded_q.push_back(step_q[j]);
            end
        end

        for (int p = 0; p < 4; p++)
        begin
            idle_mode <= idle_mode_t'(p);
            phase_items = 0;
            first_block = 1'b1;
            while (phase_items < 18)
            begin
                // mostly well-formed blocks, some noise and broken tails
                stream_q.delete();
                stream_out = 0;
                if ($urandom_range(0, 7) == 0)
                begin
                    repeat ($urandom_range(1, 6)) stream_q.push_back(8'($urandom));
                    stream_out = $urandom_range(0, 20);
                end
                else
                begin
                    target = $urandom_range(1, 40);
                    allow_bad = ($urandom_range(0, 3) == 0);
                    while (stream_out < target)
                    begin
                        flags = 8'($urandom);
                        unit_q.delete();
                        for (int i = 0; i < 8 && stream_out < target; i++)
                        begin
                            if ((stream_out == 0 && !allow_bad) || $urandom_range(0, 1) == 1)
                            begin
                                flags[i] = 1'b1;
                                unit_q.push_back(8'($urandom));
                                stream_out++;
                            end
                            else
                            begin
                                flags[i] = 1'b0;
                                lenf = $urandom_range(0, 15);
                                room = (stream_out > 4095) ? 4095 : stream_out;
                                if (room == 0 || (allow_bad && $urandom_range(0, 9) == 0))
                                    back_dist = $urandom_range(0, 1) ?
                                                0 : $urandom_range(room + 1, 4095);
                                else
                                    back_dist = $urandom_range(1, room);
                                unit_q.push_back(back_dist[7:0]);
                                unit_q.push_back({back_dist[11:8], lenf[3:0]});
                                stream_out += lenf + MIN_MATCH + 1;
                            end
                        end
                        stream_q.push_back(flags);
                        foreach (unit_q[j])
                            stream_q.push_back(unit_q[j]);
                    end
                    case ($urandom_range(0, 9))
                        0: void'(stream_q.pop_back());
                        1: stream_q.push_back(8'($urandom));
                        default: ;
                    endcase
                end

                case ($urandom_range(0, 9))
                    7: len_val = 24'((stream_out > 0) ?
                                     stream_out - $urandom_range(1, stream_out) : 0);
                    8: len_val = 24'(stream_out + $urandom_range(1, 5));
                    9: len_val = 24'($urandom);
                    default: len_val = 24'(stream_out);
                endcase

                settle();
                write_cfg(len_val);
                if (first_block && p == IDLE_NONE)
                    hold_reqs <= hold_reqs + 1;
                first_block = 1'b0;

                foreach (stream_q[i])
                begin
                    send_item(stream_q[i], i == stream_q.size() - 1);
                    lzss_decode_step(stream_q[i], i == stream_q.size() - 1, step_q);
                    foreach (step_q[j])
                        decoded_q.push_back(step_q[j]);
                    phase_items++;
                end
            end
        end

        settle();
        if (mismatches == 0)
            $display("lzss_stream_decompressor_core_tb passed");
        else
            $display("lzss_stream_decompressor_core_tb failed");
        $finish;
    end

endmodule
